### rtl/bqufi_pkg.sv
package bqufi_pkg;

    // beat field widths, fixed by the interface
    localparam int unsigned CMD_W    = 1;
    localparam int unsigned IDX_W    = 5;
    localparam int unsigned NUM_IDX  = 32;
    localparam int unsigned TAG_W    = 16;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned LEN_W    = 4;

    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned S_TUSER_W = 1;
    localparam int unsigned M_TDATA_W = 24;
    localparam int unsigned M_TUSER_W = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_TAKE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

### rtl/banked_queue_with_urgent_front_insert.sv
// a command beat is accepted into the capture registers along with its descriptor read; the descriptor
//   is updated and the result staged in S_META, then loaded into the output register in S_OUT
// tready is high only in S_IDLE, so a new command is not taken before the last result is loaded
// a stalled output holds the result; the next command is still accepted meanwhile
// reset (synchronous, active low) empties every queue through per-queue valid bits;
//   entry storage is not cleared and no clearing pass is run
module banked_queue_with_urgent_front_insert #(
    parameter int unsigned NUM_QUEUES  = 32,
    parameter int unsigned QUEUE_DEPTH = 8,
    parameter int unsigned TAG_WIDTH   = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // queue_index[4:0], entry_tag[20:5], urgent[21], zero pad[23:22]
    input  logic [bqufi_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // command[0]
    input  logic [bqufi_pkg::S_TUSER_W-1:0]    s_axis_tuser,

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // taken_tag[15:0], taken_urgent[16], entry_count[20:17], zero pad[23:21]
    output logic [bqufi_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // status[1:0]
    output logic [bqufi_pkg::M_TUSER_W-1:0]    m_axis_tuser
);

    // derived widths
    localparam int unsigned QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int unsigned PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned SUMW  = CW + 1;
    localparam int unsigned SLOTS = NUM_QUEUES * QUEUE_DEPTH;
    localparam int unsigned SAW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned SW    = (TAG_WIDTH < bqufi_pkg::TAG_W) ? TAG_WIDTH
                                                                   : bqufi_pkg::TAG_W;
    localparam int unsigned MW    = PW + CW;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_META = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    // unpacked input beat
    logic                              in_cmd;
    logic [bqufi_pkg::IDX_W-1:0]       in_idx;
    logic [bqufi_pkg::TAG_W-1:0]       in_tag;
    logic                              in_urg;
    logic                              in_acc;

    assign in_cmd = s_axis_tuser[0];
    assign in_idx = s_axis_tdata[4:0];
    assign in_tag = s_axis_tdata[20:5];
    assign in_urg = s_axis_tdata[21];
    assign in_acc = s_axis_tvalid & s_axis_tready;

    // queue index wraps modulo the queue count; small constant table
    logic [QW-1:0] q_lut [bqufi_pkg::NUM_IDX];
    always_comb begin
        for (int i = 0; i < bqufi_pkg::NUM_IDX; i++) begin
            q_lut[i] = QW'(i % NUM_QUEUES);
        end
    end

    // per-queue descriptor memory: {head pointer, fill count}
    logic [MW-1:0] meta_mem  [NUM_QUEUES];
    logic          r_meta_vld [NUM_QUEUES];
    // entry memory: {urgent, tag}, each queue a ring of QUEUE_DEPTH slots
    logic [SW:0]   slot_mem  [SLOTS];

    logic [1:0]    r_state, n_state;
    logic          r_cmd;
    logic [QW-1:0] r_q;
    logic [SW-1:0] r_tag;
    logic          r_urg;
    logic [MW-1:0] r_meta_rd;
    logic          r_meta_ok;
    logic [SW:0]   r_slot_rd;
    logic          r_took;
    logic [bqufi_pkg::STATUS_W-1:0] r_res_status, n_res_status;
    logic [CW-1:0] r_res_len, n_res_len;

    logic          r_out_vld;
    logic [bqufi_pkg::M_TDATA_W-1:0] r_out_data;
    logic [bqufi_pkg::M_TUSER_W-1:0] r_out_user;

    // descriptor update signals
    logic [PW-1:0]   cur_head;
    logic [CW-1:0]   cur_fill;
    logic [SUMW-1:0] tail_sum;
    logic [PW-1:0]   tail_ptr;
    logic [SAW-1:0]  q_base;
    logic            n_meta_we;
    logic [PW-1:0]   n_head;
    logic [CW-1:0]   n_fill;
    logic            slot_we;
    logic            slot_re;
    logic [PW-1:0]   slot_ptr;
    logic [SAW-1:0]  slot_addr;
    logic [SW:0]     slot_wdata;
    logic            n_took;
    logic            out_load;
    logic [bqufi_pkg::TAG_W-1:0] res_tag;
    logic            res_urg;

    assign s_axis_tready = (r_state == S_IDLE);

    // descriptor of an untouched queue reads as empty with head at slot 0
    assign cur_head = r_meta_ok ? r_meta_rd[MW-1:CW] : '0;
    assign cur_fill = r_meta_ok ? r_meta_rd[CW-1:0]  : '0;
    assign q_base   = SAW'(r_q) * SAW'(QUEUE_DEPTH);
    assign tail_sum = SUMW'(cur_head) + SUMW'(cur_fill);

    always_comb begin
        // tail slot, one wrap at most since head is below depth and fill at most depth
        if (tail_sum >= SUMW'(QUEUE_DEPTH)) begin
            tail_ptr = PW'(tail_sum - SUMW'(QUEUE_DEPTH));
        end else begin
            tail_ptr = PW'(tail_sum);
        end
    end

    always_comb begin
        n_meta_we    = 1'b0;
        n_head       = cur_head;
        n_fill       = cur_fill;
        slot_we      = 1'b0;
        slot_re      = 1'b0;
        slot_ptr     = cur_head;
        slot_wdata   = {r_urg, r_tag};
        n_took       = 1'b0;
        n_res_status = bqufi_pkg::ST_DONE;
        n_res_len    = cur_fill;
        if (r_cmd == bqufi_pkg::CMD_ADD) begin
            if (cur_fill == CW'(QUEUE_DEPTH)) begin
                // full queue: add rejected, nothing changes
                n_res_status = bqufi_pkg::ST_FULL;
            end else begin
                n_meta_we = 1'b1;
                slot_we   = 1'b1;
                n_fill    = cur_fill + 1'b1;
                n_res_len = cur_fill + 1'b1;
                if (r_urg) begin
                    // urgent entry becomes the new head, one slot back
                    n_head   = (cur_head == '0) ? PW'(QUEUE_DEPTH - 1) : cur_head - 1'b1;
                    slot_ptr = n_head;
                end else begin
                    slot_ptr = tail_ptr;
                end
            end
        end else begin
            if (cur_fill == '0) begin
                // empty queue: status only, tag and length are zero
                n_res_status = bqufi_pkg::ST_EMPTY;
            end else begin
                n_meta_we = 1'b1;
                slot_re   = 1'b1;
                n_took    = 1'b1;
                n_head    = (cur_head == PW'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;
                n_fill    = cur_fill - 1'b1;
                n_res_len = cur_fill - 1'b1;
            end
        end
    end

    assign slot_addr = q_base + SAW'(slot_ptr);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_META;
                end
            end
            S_META: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // the output register takes the result once it is free or being drained
    assign out_load = (r_state == S_OUT) && (!r_out_vld || m_axis_tready);
    assign res_tag  = r_took ? bqufi_pkg::TAG_W'(r_slot_rd[SW-1:0]) : '0;
    assign res_urg  = r_took ? r_slot_rd[SW] : 1'b0;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_meta_vld[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            if ((r_state == S_META) && n_meta_we) begin
                r_meta_vld[r_q] <= 1'b1;
            end
        end
    end

    // command capture and descriptor read
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd     <= in_cmd;
            r_q       <= q_lut[in_idx];
            r_tag     <= in_tag[SW-1:0];
            r_urg     <= in_urg;
            r_meta_rd <= meta_mem[q_lut[in_idx]];
            r_meta_ok <= r_meta_vld[q_lut[in_idx]];
        end
    end

    // descriptor write back and result staging
    always_ff @(posedge i_clk) begin
        if (r_state == S_META) begin
            if (n_meta_we) begin
                meta_mem[r_q] <= {n_head, n_fill};
            end
            r_res_status <= n_res_status;
            r_res_len    <= n_res_len;
            r_took       <= n_took;
        end
    end

    // entry memory port
    always_ff @(posedge i_clk) begin
        if ((r_state == S_META) && slot_we) begin
            slot_mem[slot_addr] <= slot_wdata;
        end
        if ((r_state == S_META) && slot_re) begin
            r_slot_rd <= slot_mem[slot_addr];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {3'b000, bqufi_pkg::LEN_W'(r_res_len), res_urg, res_tag};
            r_out_user <= r_res_status;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

`ifndef NO_ASSERTIONS
    // a result appears only after the sequencer has finished a command
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state) == S_OUT)
        else $error("result beat without a finished command");

    // a descriptor write never records more entries than a queue holds
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_META) && n_meta_we |-> n_fill <= CW'(QUEUE_DEPTH))
        else $error("queue fill beyond depth");

    // an empty take reports no entry
    a_empty_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == bqufi_pkg::ST_EMPTY)
            |-> m_axis_tdata == '0)
        else $error("empty status with entry data");

    // a rejected add changes no state and reports a length of the full depth
    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_META) && (n_res_status == bqufi_pkg::ST_FULL)
            |-> !n_meta_we && !slot_we && (n_res_len == CW'(QUEUE_DEPTH)))
        else $error("full status with a state change");
`endif

endmodule
